// ----- rtl/c2u_pkg.sv -----
// c2u_pkg: shared types and constants of the charset to utf-8 transcoder
// no dependencies; used by every module in rtl/
package c2u_pkg;

  typedef enum logic [1:0] {
    MODE_ASCII  = 2'd0,
    MODE_LATIN1 = 2'd1,
    MODE_RAW    = 2'd2,
    MODE_UTF8   = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_END = 2'd1,
    ST_ERR = 2'd2,
    ST_RSV = 2'd3
  } status_e;

  localparam mode_e       MODE_RESET = MODE_RAW;
  localparam logic [7:0]  ASCII_MAX  = 8'd127;
  localparam logic [7:0]  REPL_B0    = 8'hEF;
  localparam logic [7:0]  REPL_B1    = 8'hBF;
  localparam logic [7:0]  REPL_B2    = 8'hBD;
  localparam logic [7:0]  CONT_LO    = 8'h80;
  localparam logic [7:0]  CONT_HI    = 8'hBF;

  // one input item's output run, up to four bytes
  typedef struct packed {
    logic [3:0][7:0] bytes;
    logic [1:0]      nres_m1;
    status_e         status;
  } burst_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

endpackage

// ----- rtl/charset_to_utf8_transcoder_unit.sv -----
// charset_to_utf8_transcoder_unit: top level of the charset to utf-8 transcoder
// depends on c2u_pkg, c2u_front, c2u_queue, c2u_back
//
// usage
//   input stream: one transfer per source byte, tdata = data_byte,
//   tlast = end of input, tuser = source error (wins over tlast)
//   output stream: one transfer per utf-8 byte, tdata = byte (zero on
//   end or error), tuser = status (0 ok, 1 end of text, 2 error),
//   tlast marks the final byte of one character's run
//   apb port: charset_mode at byte address 0 (0 us-ascii, 1 iso-8859-1,
//   2 other raw, 3 utf-8); a write also drops any open utf-8 sequence
// timing
//   an input transfer is taken every cycle while the run queue has room;
//   the first output byte passes through the run queue and then the output
//   register; the output side moves one byte per cycle while the receiver
//   is ready, and an item yields 0 to 4 output bytes
// reset and stall
//   reset gives mode 2, no open sequence and an empty queue; a stalled
//   receiver holds the output register, the queue fills and then
//   s_axis_tready drops until room frees up
module charset_to_utf8_transcoder_unit #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,   // [0] source_error
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic [1:0]  m_axis_tuser,   // [1:0] status
  output logic        m_axis_tlast,
  // apb configuration
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  c2u_pkg::mode_e  mode_q;
  logic            cfg_wr;
  logic            take;
  logic            emit;
  logic            pop;
  c2u_pkg::burst_t fe_burst;
  c2u_pkg::burst_t head;
  c2u_pkg::qstat_t qstat;

  // configuration register, word 0 only
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {30'd0, mode_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= c2u_pkg::MODE_RESET;
    end else if (cfg_wr) begin
      mode_q <= c2u_pkg::mode_e'(pwdata[1:0]);
    end
  end

  // front takes an item whenever the queue has a free slot
  assign s_axis_tready = !qstat.full;
  assign take          = s_axis_tvalid && s_axis_tready;

  c2u_front u_front (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .mode_i         (mode_q),
    .cfg_clear_i    (cfg_wr),
    .take_i         (take),
    .data_byte_i    (s_axis_tdata),
    .end_of_input_i (s_axis_tlast),
    .source_error_i (s_axis_tuser),
    .emit_o         (emit),
    .burst_o        (fe_burst)
  );

  c2u_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (take && emit),
    .push_data_i (fe_burst),
    .pop_i       (pop),
    .head_o      (head),
    .stat_o      (qstat)
  );

  c2u_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!qstat.empty),
    .head_i       (head),
    .pop_o        (pop),
    .m_tvalid     (m_axis_tvalid),
    .m_tready     (m_axis_tready),
    .m_tdata      (m_axis_tdata),
    .m_tuser      (m_axis_tuser),
    .m_tlast      (m_axis_tlast)
  );

  // non-ok results carry a zero byte and close their run
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && (m_axis_tuser != c2u_pkg::ST_OK) |-> (m_axis_tdata == 8'd0) && m_axis_tlast)
    else $error("end or error result with data or without tlast");

  // the reserved status code never leaves the block
  a_status_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tuser != c2u_pkg::ST_RSV))
    else $error("reserved status on output");

  // queue cannot be both full and empty
  a_queue_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(qstat.full && qstat.empty))
    else $error("queue full and empty at once");

  // the back end only pops what is there
  a_pop_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty)
    else $error("pop from empty queue");

endmodule

// ----- rtl/c2u_front.sv -----
// c2u_front: classifies each source byte and keeps the utf-8 sequence state
// depends on c2u_pkg
module c2u_front (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  c2u_pkg::mode_e   mode_i,
  input  logic             cfg_clear_i,
  input  logic             take_i,
  input  logic [7:0]       data_byte_i,
  input  logic             end_of_input_i,
  input  logic             source_error_i,
  output logic             emit_o,
  output c2u_pkg::burst_t  burst_o
);

  logic [2:0][7:0] held_q, held_d;
  logic [1:0]      cnt_q, cnt_d;
  logic [2:0]      seq_q, seq_d;
  logic [7:0]      lo, hi;
  logic [7:0]      b;

  assign b = data_byte_i;

  always_comb begin
    emit_o  = 1'b0;
    burst_o = '0;
    held_d  = held_q;
    cnt_d   = cnt_q;
    seq_d   = seq_q;
    lo      = c2u_pkg::CONT_LO;
    hi      = c2u_pkg::CONT_HI;
    if (source_error_i) begin
      emit_o         = 1'b1;
      burst_o.status = c2u_pkg::ST_ERR;
      held_d = '0; cnt_d = '0; seq_d = '0;
    end else if (end_of_input_i) begin
      emit_o         = 1'b1;
      burst_o.status = (mode_i == c2u_pkg::MODE_UTF8 && seq_q != 3'd0) ?
                       c2u_pkg::ST_ERR : c2u_pkg::ST_END;
      held_d = '0; cnt_d = '0; seq_d = '0;
    end else begin
      case (mode_i)
        c2u_pkg::MODE_ASCII: begin
          emit_o = 1'b1;
          if (b > c2u_pkg::ASCII_MAX) begin
            burst_o.status = c2u_pkg::ST_ERR;
          end else begin
            burst_o.bytes[0] = b;
          end
        end
        c2u_pkg::MODE_LATIN1: begin
          emit_o = 1'b1;
          if (b[7]) begin
            burst_o.bytes[0] = {2'b11, 4'b0000, b[7:6]};
            burst_o.bytes[1] = {2'b10, b[5:0]};
            burst_o.nres_m1  = 2'd1;
          end else begin
            burst_o.bytes[0] = b;
          end
        end
        c2u_pkg::MODE_RAW: begin
          emit_o = 1'b1;
          if (b[7]) begin
            burst_o.bytes[0] = c2u_pkg::REPL_B0;
            burst_o.bytes[1] = c2u_pkg::REPL_B1;
            burst_o.bytes[2] = c2u_pkg::REPL_B2;
            burst_o.nres_m1  = 2'd2;
          end else begin
            burst_o.bytes[0] = b;
          end
        end
        default: begin
          if (seq_q == 3'd0) begin
            // lead byte
            if (!b[7]) begin
              emit_o           = 1'b1;
              burst_o.bytes[0] = b;
            end else if (b inside {[8'hC2:8'hDF], [8'hE0:8'hEF], [8'hF0:8'hF4]}) begin
              held_d[0] = b;
              cnt_d     = 2'd1;
              if (b inside {[8'hC2:8'hDF]}) begin
                seq_d = 3'd2;
              end else if (b inside {[8'hE0:8'hEF]}) begin
                seq_d = 3'd3;
              end else begin
                seq_d = 3'd4;
              end
            end else begin
              emit_o         = 1'b1;
              burst_o.status = c2u_pkg::ST_ERR;
              held_d = '0; cnt_d = '0; seq_d = '0;
            end
          end else begin
            // second byte range is narrowed after some lead bytes
            if (cnt_q == 2'd1) begin
              case (held_q[0])
                8'hE0:   lo = 8'hA0;
                8'hED:   hi = 8'h9F;
                8'hF0:   lo = 8'h90;
                8'hF4:   hi = 8'h8F;
                default: ;
              endcase
            end
            if (b < lo || b > hi) begin
              emit_o         = 1'b1;
              burst_o.status = c2u_pkg::ST_ERR;
              held_d = '0; cnt_d = '0; seq_d = '0;
            end else if (({1'b0, cnt_q} + 3'd1) < seq_q) begin
              held_d[cnt_q] = b;
              cnt_d         = cnt_q + 2'd1;
            end else begin
              emit_o           = 1'b1;
              burst_o.bytes[0] = held_q[0];
              burst_o.bytes[1] = (cnt_q == 2'd1) ? b : held_q[1];
              burst_o.bytes[2] = (cnt_q == 2'd2) ? b : held_q[2];
              burst_o.bytes[3] = b;
              burst_o.nres_m1  = cnt_q;
              held_d = '0; cnt_d = '0; seq_d = '0;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_q <= '0;
      cnt_q  <= '0;
      seq_q  <= '0;
    end else if (cfg_clear_i) begin
      held_q <= '0;
      cnt_q  <= '0;
      seq_q  <= '0;
    end else if (take_i) begin
      held_q <= held_d;
      cnt_q  <= cnt_d;
      seq_q  <= seq_d;
    end
  end

endmodule

// ----- rtl/c2u_queue.sv -----
// c2u_queue: short fifo of output runs between front and back
// depends on c2u_pkg
module c2u_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  c2u_pkg::burst_t  push_data_i,
  input  logic             pop_i,
  output c2u_pkg::burst_t  head_o,
  output c2u_pkg::qstat_t  stat_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  c2u_pkg::burst_t mem_q [DEPTH];
  logic [PW-1:0] wr_q, rd_q;
  logic [CW-1:0] cnt_q;

  assign stat_o.full  = (cnt_q == CW'(DEPTH));
  assign stat_o.empty = (cnt_q == '0);
  assign head_o       = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + PW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + PW'(1);
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + CW'(1);
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - CW'(1);
      end
    end
  end

endmodule

// ----- rtl/c2u_back.sv -----
// c2u_back: serialises queued runs into single output bytes
// depends on c2u_pkg
module c2u_back (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             head_valid_i,
  input  c2u_pkg::burst_t  head_i,
  output logic             pop_o,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [7:0]       m_tdata,
  output logic [1:0]       m_tuser,
  output logic             m_tlast
);

  logic       valid_q, valid_d;
  logic [1:0] idx_q, idx_d;
  logic       load, at_end;
  logic [7:0] byte_q;
  logic [1:0] user_q;
  logic       last_q;

  assign load   = head_valid_i && (!valid_q || m_tready);
  assign at_end = (idx_q == head_i.nres_m1);
  assign pop_o  = load && at_end;

  always_comb begin
    valid_d = valid_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = 1'b1;
      idx_d   = at_end ? 2'd0 : idx_q + 2'd1;
    end else if (m_tready) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      byte_q <= head_i.bytes[idx_q];
      user_q <= head_i.status;
      last_q <= at_end;
    end
  end

  assign m_tvalid = valid_q;
  assign m_tdata  = byte_q;
  assign m_tuser  = user_q;
  assign m_tlast  = last_q;

endmodule
